[sv/sssp_pkg.sv]
// Shared package for the shortest-path relaxation table.
// Field widths, opcodes, distance constants and controller/datapath bundles.
// No dependencies.
package sssp_pkg;

  localparam int NODE_COUNT_DEF = 1024;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 10;
  localparam int WEIGHT_W = 32;
  localparam int DIST_W   = 30;
  localparam int CNT_W    = 11;

  localparam int IN_DATA_W  = 56;  // 52 payload bits padded to bytes
  localparam int OUT_DATA_W = 80;  // 73 payload bits padded to bytes

  localparam logic [DIST_W-1:0] INF_DIST  = 30'h3FFF_FFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 11'h7FF;

  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_RELAX = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic rd_target;  // table read address is the edge target, else the node
    logic latch_src;  // hold the source-node distance read last cycle
    logic do_init;
    logic do_relax;
    logic do_read;
    logic do_clear;
    logic emit;       // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register empty or being drained this cycle
  } status_t;

endpackage

[sv/sssp_ctrl.sv]
// Controller FSM for the shortest-path relaxation table.
// Sequences table reads, the update step and the result handoff.
// Depends on sssp_pkg.
module sssp_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [sssp_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  sssp_pkg::status_t        status,
  output sssp_pkg::cmd_t           cmd
);
  import sssp_pkg::*;

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_INIT       = 4'd1;
  localparam logic [3:0] ST_FETCH_SRC  = 4'd2;
  localparam logic [3:0] ST_FETCH_DST  = 4'd3;
  localparam logic [3:0] ST_RELAX      = 4'd4;
  localparam logic [3:0] ST_FETCH_NODE = 4'd5;
  localparam logic [3:0] ST_READ       = 4'd6;
  localparam logic [3:0] ST_CLEAR      = 4'd7;
  localparam logic [3:0] ST_EMIT       = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_op)
            OP_INIT:  state_next = ST_INIT;
            OP_RELAX: state_next = ST_FETCH_SRC;
            OP_READ:  state_next = ST_FETCH_NODE;
            default:  state_next = ST_CLEAR;
          endcase
        end
      end
      ST_INIT: begin
        cmd.do_init = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_FETCH_SRC: begin
        state_next = ST_FETCH_DST;
      end
      ST_FETCH_DST: begin
        cmd.rd_target = 1'b1;
        cmd.latch_src = 1'b1;
        state_next    = ST_RELAX;
      end
      ST_RELAX: begin
        cmd.do_relax = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_FETCH_NODE: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.do_read = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_CLEAR: begin
        cmd.do_clear = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/sssp_datapath.sv]
// Datapath for the shortest-path relaxation table: distance memory,
// source-node register, relax adder/compare, statistics and output register.
// Depends on sssp_pkg.
module sssp_datapath #(
  parameter int NODE_COUNT = sssp_pkg::NODE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sssp_pkg::IDX_W-1:0]      cfg_wdata,
  input  logic [sssp_pkg::IDX_W-1:0]      in_node,
  input  logic [sssp_pkg::IDX_W-1:0]      in_target,
  input  logic [sssp_pkg::WEIGHT_W-1:0]   in_weight,
  input  sssp_pkg::cmd_t                  cmd,
  output sssp_pkg::status_t               status,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sssp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sssp_pkg::*;

  // Indices are 10 bits, so no more than 1024 entries are ever addressed.
  localparam int MEM_DEPTH = (NODE_COUNT < (1 << IDX_W)) ? NODE_COUNT : (1 << IDX_W);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic [DIST_W-1:0] mem [MEM_DEPTH];

  logic [IDX_W-1:0]    source_reg;
  logic [IDX_W-1:0]    node_r;
  logic [IDX_W-1:0]    target_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [DIST_W-1:0]   rd_data;
  logic [DIST_W-1:0]   src_dist;

  logic [DIST_W-1:0] res_dist;
  logic              res_improved;
  logic              res_reached;
  logic [CNT_W-1:0]  visited_cnt;
  logic [DIST_W-1:0] max_dist;

  logic [DIST_W-1:0] out_dist;
  logic              out_improved;
  logic              out_reached;
  logic [CNT_W-1:0]  out_cnt;
  logic [DIST_W-1:0] out_max;

  logic              node_ok;
  logic              target_ok;
  logic [ADDR_W-1:0] node_addr;
  logic [ADDR_W-1:0] target_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DIST_W-1:0] wr_data;

  logic [DIST_W-1:0] node_dist;
  logic [DIST_W-1:0] dest_dist;
  logic [DIST_W-1:0] init_dist;
  logic [WEIGHT_W:0] relax_sum;
  logic              better;

  assign node_ok     = (32'(node_r) < 32'(NODE_COUNT));
  assign target_ok   = (32'(target_r) < 32'(NODE_COUNT));
  assign node_addr   = ADDR_W'(node_r);
  assign target_addr = ADDR_W'(target_r);
  assign rd_addr     = cmd.rd_target ? target_addr : node_addr;

  // Out-of-range nodes read as unreached.
  assign node_dist = node_ok ? rd_data : INF_DIST;
  assign dest_dist = target_ok ? rd_data : INF_DIST;
  assign init_dist = (node_r == source_reg) ? '0 : INF_DIST;

  // Exact sum; an unreached source can never beat an in-range target.
  assign relax_sum = {1'b0, weight_r} + (WEIGHT_W+1)'(src_dist);
  assign better    = target_ok && (relax_sum < (WEIGHT_W+1)'(dest_dist));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_addr;
    wr_data = init_dist;
    if (cmd.do_init) begin
      wr_en = node_ok;
    end else if (cmd.do_relax) begin
      wr_en   = better;
      wr_addr = target_addr;
      wr_data = relax_sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_reg <= '0;
    end else if (cfg_we) begin
      source_reg <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node_r   <= in_node;
      target_r <= in_target;
      weight_r <= in_weight;
    end
    if (cmd.latch_src) begin
      src_dist <= node_dist;
    end
    if (cmd.do_init) begin
      res_dist     <= node_ok ? init_dist : INF_DIST;
      res_improved <= 1'b0;
      res_reached  <= node_ok && (init_dist != INF_DIST);
    end
    if (cmd.do_relax) begin
      res_dist     <= better ? relax_sum[DIST_W-1:0] : dest_dist;
      res_improved <= better;
      res_reached  <= better || (dest_dist != INF_DIST);
    end
    if (cmd.do_read) begin
      res_dist     <= node_dist;
      res_improved <= 1'b0;
      res_reached  <= (node_dist != INF_DIST);
    end
    if (cmd.do_clear) begin
      res_dist     <= '0;
      res_improved <= 1'b0;
      res_reached  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited_cnt <= '0;
      max_dist    <= '0;
    end else if (cmd.do_clear) begin
      visited_cnt <= '0;
      max_dist    <= '0;
    end else if (cmd.do_read && (node_dist != INF_DIST)) begin
      if (visited_cnt != COUNT_MAX) begin
        visited_cnt <= visited_cnt + 1'b1;
      end
      if (max_dist < node_dist) begin
        max_dist <= node_dist;
      end
    end
  end

  // Output register: the controller only emits when it is free.
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dist     <= res_dist;
      out_improved <= res_improved;
      out_reached  <= res_reached;
      out_cnt      <= visited_cnt;
      out_max      <= max_dist;
    end
  end

  assign m_tdata = {7'b0, out_max, out_cnt, out_reached, out_improved, out_dist};

endmodule

[sv/sssp_edge_relaxation_table_top.sv]
// Top level of the shortest-path edge relaxation table.
// Joins the controller (sssp_ctrl) and the datapath (sssp_datapath); uses sssp_pkg.
//
// Usage:
//   Items arrive on the s_ group: s_tuser carries the opcode (init node, relax
//   edge, read node, clear statistics), s_tdata the node index, edge target
//   and edge weight. Each item yields exactly one result on the m_ group:
//   distance, improved flag, reached flag, visited count and largest distance.
//   cfg_we/cfg_wdata write the source node; write it only while idle.
//   One item is in work at a time. From the accepting edge the controller steps
//   through INIT or CLEAR, FETCH_NODE and READ for a read, or FETCH_SRC, FETCH_DST
//   and RELAX for a relax, then EMIT, which loads the result into the output
//   register; the fetch steps are set by the single read port of the distance
//   memory (one registered read per cycle, source then target for a relax).
//   s_tready is high in the cycle after that load. The result sits in an output
//   register, so the next item is accepted while it waits; if m_tready stays
//   low, the following result waits in the controller until the register is free.
//   Reset clears the statistics, the source node and the handshake state; the
//   distance table is not cleared, so every node must be initialized before
//   it is read or relaxed from.
module sssp_edge_relaxation_table_top #(
  parameter int NODE_COUNT = sssp_pkg::NODE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sssp_pkg::IDX_W-1:0]      cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [9:0] node_index, [19:10] edge_target, [51:20] edge_weight, rest zero
  input  logic [sssp_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] opcode
  input  logic [sssp_pkg::OP_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [29:0] distance, [30] improved, [31] reached, [42:32] visited_count,
  // [72:43] largest distance, rest zero
  output logic [sssp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sssp_pkg::*;

  cmd_t    cmd;
  status_t status;

  sssp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sssp_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_node   (s_tdata[9:0]),
    .in_target (s_tdata[19:10]),
    .in_weight (s_tdata[51:20]),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // One item at a time: the controller is busy right after a transfer in.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // An improvement always leaves a finite distance behind.
  a_improved_finite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[30]) |-> (m_tdata[29:0] != INF_DIST))
    else $error("improved result with infinite distance");

  a_reached_finite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[31]) |-> (m_tdata[29:0] != INF_DIST))
    else $error("reached result with infinite distance");

  a_max_finite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[72:43] != INF_DIST))
    else $error("largest distance holds infinity");

endmodule

[tb/sssp_edge_relaxation_table_top_tb.sv]
// Testbench for sssp_edge_relaxation_table_top: directed corner items, a read
// burst on one reached node, then random graph rounds, checked by a predictor.
// Depends on sssp_pkg and the top level only.
module sssp_edge_relaxation_table_top_tb;
  import sssp_pkg::*;

  localparam int NODES         = NODE_COUNT_DEF;
  localparam int MAX_GAP       = 18;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 190;
  localparam int RANDOM_PHASES = 6;
  localparam int BURST_READS   = 300;

  // result fields from the highest bit down, as carried on m_tdata
  typedef struct packed {
    logic [DIST_W-1:0] largest_dist;
    logic [CNT_W-1:0]  visited_count;
    logic              reached;
    logic              improved;
    logic [DIST_W-1:0] distance;
  } relax_result_t;

  class distance_scoreboard;
    logic [DIST_W-1:0] dist_mem [NODES];
    bit                written [NODES];
    int                written_q[$];
    logic [IDX_W-1:0]  source_node;
    logic [CNT_W-1:0]  reach_cnt;
    logic [DIST_W-1:0] max_dist;
    relax_result_t     expected_q[$];
    int                errors;
    int                checked;
    int                improved_cnt;
    bit                saw_saturation;

    function new();
      source_node = '0;
      reach_cnt   = '0;
      max_dist    = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [IDX_W-1:0] any_written();
      return IDX_W'(written_q[$urandom_range(0, written_q.size() - 1)]);
    endfunction

    function void store(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] d);
      dist_mem[idx] = d;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_q.insert(written_q.size(), int'(idx));
      end
    endfunction

    // Updates the distance state for one accepted item and queues its result.
    function void note_input(logic [OP_W-1:0] op, logic [IDX_W-1:0] node,
                             logic [IDX_W-1:0] target, logic [WEIGHT_W-1:0] weight);
      relax_result_t r;
      logic [WEIGHT_W:0] sum;
      r = '0;
      case (op)
        OP_INIT: begin
          store(node, (node == source_node) ? '0 : INF_DIST);
          r.distance = dist_mem[node];
          r.reached  = r.distance < INF_DIST;
        end
        OP_RELAX: begin
          // exact 33-bit sum, no wrap
          sum = {1'b0, weight} + {3'b0, dist_mem[node]};
          if (sum < {3'b0, dist_mem[target]}) begin
            store(target, sum[DIST_W-1:0]);
            r.improved = 1'b1;
            improved_cnt++;
          end
          r.distance = dist_mem[target];
          r.reached  = r.distance < INF_DIST;
        end
        OP_READ: begin
          r.distance = dist_mem[node];
          if (r.distance < INF_DIST) begin
            r.reached = 1'b1;
            if (reach_cnt != COUNT_MAX) reach_cnt++;
            else saw_saturation = 1'b1;
            if (max_dist < r.distance) max_dist = r.distance;
          end
        end
        OP_CLEAR: begin
          reach_cnt = '0;
          max_dist  = '0;
        end
        default: ;
      endcase
      r.visited_count = reach_cnt;
      r.largest_dist  = max_dist;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      relax_result_t got;
      relax_result_t want;
      got = relax_result_t'(data[$bits(relax_result_t)-1:0]);
      if (expected_q.size() == 0) begin
        $error("result %h arrived with nothing pending", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.distance !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, got.distance);
        errors++;
      end
      if (got.improved !== want.improved) begin
        $error("improved: expected %0d, got %0d", want.improved, got.improved);
        errors++;
      end
      if (got.reached !== want.reached) begin
        $error("reached: expected %0d, got %0d", want.reached, got.reached);
        errors++;
      end
      if (got.visited_count !== want.visited_count) begin
        $error("visited_count: expected %0d, got %0d", want.visited_count, got.visited_count);
        errors++;
      end
      if (got.largest_dist !== want.largest_dist) begin
        $error("largest_dist: expected %0d, got %0d", want.largest_dist, got.largest_dist);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = OP_INIT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  distance_scoreboard sb;
  bit src_quiet = 1'b0;
  bit dst_quiet = 1'b0;
  int items_sent = 0;
  int stalled_cycles = 0;

  sssp_edge_relaxation_table_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [IDX_W-1:0] rand_node();
    return IDX_W'($urandom_range(0, NODES - 1));
  endfunction

  // Mostly small weights so relaxations keep improving; some land the sum just
  // at or under infinity, some are full-range.
  function automatic logic [WEIGHT_W-1:0] pick_weight(logic [IDX_W-1:0] from);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 64);
    else if (r < 65) return '0;
    else if (r < 75) return $urandom;
    else if (r < 82) return '1;
    else if (r < 90)
      return WEIGHT_W'(INF_DIST) - WEIGHT_W'(sb.dist_mem[from]) - $urandom_range(0, 2);
    else return $urandom_range(0, 1 << 20);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] node,
                           input logic [IDX_W-1:0] target, input logic [WEIGHT_W-1:0] weight);
    int unsigned gap;
    gap = pick_gap(src_quiet);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W - WEIGHT_W - 2*IDX_W){1'b0}}, weight, target, node};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, node, target, weight);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_source(input logic [IDX_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.source_node = v;
  endtask

  // Stray item on already initialized nodes, or an init or a clear anywhere.
  task automatic send_noise();
    logic [IDX_W-1:0] a;
    case ($urandom_range(0, 3))
      0: send_item(OP_INIT, rand_node(), rand_node(), $urandom);
      1: begin
        a = sb.any_written();
        send_item(OP_RELAX, a, sb.any_written(), pick_weight(a));
      end
      2: send_item(OP_READ, sb.any_written(), rand_node(), $urandom);
      default: send_item(OP_CLEAR, rand_node(), rand_node(), $urandom);
    endcase
  endtask

  // Init a small node set, relax random edges among it, then read some back.
  task automatic run_graph_round();
    logic [IDX_W-1:0] members[$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int unsigned k;
    k = $urandom_range(2, 12);
    src_quiet = ($urandom_range(0, 3) == 0);
    dst_quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1)) members.insert(members.size(), sb.source_node);
    while (members.size() < k) members.insert(members.size(), rand_node());
    foreach (members[i]) send_item(OP_INIT, members[i], rand_node(), $urandom);
    repeat (3 * k) begin
      if ($urandom_range(0, 99) < 85) begin
        a = members[$urandom_range(0, members.size() - 1)];
        b = members[$urandom_range(0, members.size() - 1)];
        send_item(OP_RELAX, a, b, pick_weight(a));
      end else begin
        send_noise();
      end
    end
    foreach (members[i])
      if ($urandom_range(0, 3) != 0) send_item(OP_READ, members[i], rand_node(), $urandom);
    if ($urandom_range(0, 5) == 0) send_item(OP_CLEAR, rand_node(), rand_node(), $urandom);
  endtask

  initial begin
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap(dst_quiet);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == IDLE_LIMIT) begin
      $error("no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    int phase_start;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_source(IDX_W'(5));
    send_item(OP_INIT, 5, 0, 0);
    send_item(OP_INIT, 1023, 1023, '1);
    send_item(OP_INIT, 0, 0, 0);
    send_item(OP_READ, 1023, 0, 0);            // unreached read, no count
    send_item(OP_RELAX, 5, 1023, 0);           // zero weight improves
    send_item(OP_RELAX, 5, 0, '1);             // exact sum far beyond infinity
    send_item(OP_RELAX, 1023, 5, 0);           // equal distance, no improvement
    send_item(OP_INIT, 1023, 0, 0);
    send_item(OP_RELAX, 1023, 0, 0);           // unreached source never improves
    send_item(OP_RELAX, 5, 0, 32'h3FFF_FFFF);  // sum equals infinity
    send_item(OP_RELAX, 5, 0, 32'h3FFF_FFFE);  // largest finite distance
    send_item(OP_READ, 0, 1023, '1);
    send_item(OP_READ, 0, 0, 0);               // same node counted again
    send_item(OP_READ, 5, 0, 0);
    send_item(OP_RELAX, 0, 0, 0);              // self loop
    send_item(OP_CLEAR, 1023, 1023, '1);
    send_item(OP_READ, 1023, 0, 0);
    send_item(OP_INIT, 512, 512, 32'h8000_0000);
    send_item(OP_RELAX, 5, 512, 1);
    send_item(OP_READ, 512, 0, 0);

    // Back-to-back read burst on a reached node; every read is counted.
    write_source(IDX_W'(1023));
    src_quiet = 1'b1;
    dst_quiet = 1'b1;
    send_item(OP_INIT, 1023, 0, 0);
    repeat (BURST_READS) send_item(OP_READ, 1023, rand_node(), $urandom);
    send_item(OP_CLEAR, 0, 0, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       write_source('0);
        1:       write_source('1);
        default: write_source(rand_node());
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_graph_round();
    end

    wait_drained();
    $display("summary: %0d items sent, %0d results checked, %0d improving relaxations",
             items_sent, sb.checked, sb.improved_cnt);
    $display("summary: source settings 5, 1023, 0 and random; visited count saturated: %0d",
             sb.saw_saturation);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sssp_pkg.sv
sv/sssp_ctrl.sv
sv/sssp_datapath.sv
sv/sssp_edge_relaxation_table_top.sv
tb/sssp_edge_relaxation_table_top_tb.sv
